### rtl/lfu_pkg.sv
// Package for the lazy flags unit: codes, state and flag types, kind decoding.
package lfu_pkg;

    localparam logic [2:0] CMD_RECORD = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_FORCE  = 3'd3;
    localparam logic [2:0] CMD_TEST   = 3'd4;

    localparam logic [2:0] FSEL_CF = 3'd0;
    localparam logic [2:0] FSEL_PF = 3'd1;
    localparam logic [2:0] FSEL_AF = 3'd2;
    localparam logic [2:0] FSEL_ZF = 3'd3;
    localparam logic [2:0] FSEL_SF = 3'd4;
    localparam logic [2:0] FSEL_OF = 3'd5;

    localparam logic [2:0] COND_O  = 3'd0;
    localparam logic [2:0] COND_C  = 3'd1;
    localparam logic [2:0] COND_Z  = 3'd2;
    localparam logic [2:0] COND_BE = 3'd3;
    localparam logic [2:0] COND_S  = 3'd4;
    localparam logic [2:0] COND_P  = 3'd5;
    localparam logic [2:0] COND_L  = 3'd6;
    localparam logic [2:0] COND_LE = 3'd7;

    localparam logic [5:0] K_MUL         = 6'd0;
    localparam logic [5:0] K_BIT         = 6'd1;
    localparam logic [5:0] K_ARITH_FIRST = 6'd2;
    localparam logic [5:0] K_ARITH_LAST  = 6'd28;
    localparam logic [5:0] K_SHLD16      = 6'd29;
    localparam logic [5:0] K_SHLD32      = 6'd30;
    localparam logic [5:0] K_SHRD16      = 6'd31;
    localparam logic [5:0] K_SHRD32      = 6'd32;
    localparam logic [5:0] K_FULL        = 6'd33;

    localparam int NUM_GROUPS = 9;
    localparam int GROUP_SPAN = 3;

    localparam logic [31:0] WRITE_MASK    = 32'h003F_7FD5;
    localparam logic [31:0] MATERIAL_MASK = 32'h0000_08D5;
    localparam logic [31:0] OAC_MASK      = 32'h0000_0811;
    localparam logic [31:0] FLAGS_RESET   = 32'h0000_0002;

    localparam int BIT_CF = 0;
    localparam int BIT_PF = 2;
    localparam int BIT_AF = 4;
    localparam int BIT_ZF = 6;
    localparam int BIT_SF = 7;
    localparam int BIT_IF = 9;
    localparam int BIT_OF = 11;

    typedef enum logic [3:0] {
        G_ADD, G_SUB, G_ADC, G_SBB, G_SHL, G_SHR, G_SAR, G_INC, G_DEC, G_OTHER
    } t_group;

    typedef enum logic [1:0] {WID_8, WID_16, WID_32} t_width;

    typedef struct packed {
        t_group grp;
        t_width wid;
        logic [5:0] kind;
    } t_decode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] res;
        logic [31:0] opa;
        logic [31:0] opb;
        logic        sign_ovr;
        logic        parity_ovr;
        logic [31:0] fstore;
    } t_lfu_state;

    typedef struct packed {
        logic        of_f;
        logic        sf_f;
        logic        zf_f;
        logic        af_f;
        logic        pf_f;
        logic        cf_f;
        logic [31:0] word;
    } t_flag_view;

    localparam t_lfu_state STATE_RESET = '{
        kind: K_FULL, res: 32'd1, opa: 32'd0, opb: 32'd0,
        sign_ovr: 1'b0, parity_ovr: 1'b0, fstore: FLAGS_RESET
    };

    function automatic t_decode lfu_decode(input logic [5:0] kind);
        t_decode    d;
        logic [5:0] kn;
        logic [4:0] idx;
        logic [4:0] rem;
        logic [3:0] g;
        kn  = (kind > K_FULL) ? K_FULL : kind;
        idx = 5'(kn - K_ARITH_FIRST);
        g   = 4'd0;
        for (int i = 1; i < NUM_GROUPS; i++) begin
            if (idx >= 5'(GROUP_SPAN * i)) begin
                g = 4'(i);
            end
        end
        rem = 5'(idx - 5'(GROUP_SPAN * int'(g)));
        d.kind = kn;
        if (kn >= K_ARITH_FIRST && kn <= K_ARITH_LAST) begin
            d.grp = t_group'(g);
            d.wid = (rem == 5'd0) ? WID_8 : ((rem == 5'd1) ? WID_16 : WID_32);
        end else begin
            d.grp = G_OTHER;
            d.wid = WID_32;
        end
        return d;
    endfunction

    function automatic logic lfu_msb(input logic [31:0] v, input t_width w);
        logic b;
        unique case (w)
            WID_8:   b = v[7];
            WID_16:  b = v[15];
            default: b = v[31];
        endcase
        return b;
    endfunction

    function automatic logic [31:0] lfu_mask(input t_width w);
        logic [31:0] m;
        unique case (w)
            WID_8:   m = 32'h0000_00FF;
            WID_16:  m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] lfu_wval(input t_width w);
        logic [5:0] n;
        unique case (w)
            WID_8:   n = 6'd8;
            WID_16:  n = 6'd16;
            default: n = 6'd32;
        endcase
        return n;
    endfunction

    // Bit of a at position base - cnt, zero when that position is outside the word.
    function automatic logic lfu_top_bit(input logic [31:0] a, input logic [5:0] base,
                                         input logic [31:0] cnt);
        logic [5:0] pos;
        logic       b;
        pos = base - cnt[5:0];
        b   = 1'b0;
        if (cnt <= {26'd0, base} && !pos[5]) begin
            b = a[pos[4:0]];
        end
        return b;
    endfunction

endpackage

### rtl/x86_lazy_flags_unit_top.sv
// Top level of the lazy x86 flags unit: input stage, state update and result register.
//
// The unit takes one command item on the input channel (i_valid, o_ready) and
// returns exactly one result item on the output channel (o_valid, i_ready).
// A command records an ALU operation, reads EFLAGS, writes EFLAGS, forces one
// flag or tests a condition code; every result carries the EFLAGS word after
// the command, the condition result and the interrupt flag change bit.
// An accepted item is held in the input register, where the state update and
// the flag evaluation run; its result is loaded into the output register when
// the item advances, which waits while the output register holds a result that
// the receiver has not taken. One item is accepted and one result delivered
// every cycle while the receiver holds i_ready high. The two register stages
// are the input and output registers; the old and new state evaluation sits between.
// When the receiver holds i_ready low, the result waits in the output register
// while one more item waits in the input register; o_ready then falls.
// Reset clears both stages and returns the state to full-update kind, a
// nonzero last result and a flags word of 0x00000002.
module x86_lazy_flags_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [5:0]  i_op_kind,
    input  logic [31:0] i_result_value,
    input  logic [31:0] i_first_operand,
    input  logic [31:0] i_second_operand,
    input  logic [31:0] i_new_flags,
    input  logic [2:0]  i_flag_select,
    input  logic        i_flag_value,
    input  logic [3:0]  i_condition_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_flags_out,
    output logic        o_condition_true,
    output logic        o_interrupt_flag_changed
);
    import lfu_pkg::*;

    logic        r_in_vld;
    logic [2:0]  r_cmd;
    logic [5:0]  r_kind;
    logic [31:0] r_res;
    logic [31:0] r_opa;
    logic [31:0] r_opb;
    logic [31:0] r_nflags;
    logic [2:0]  r_fsel;
    logic        r_fval;
    logic [3:0]  r_cc;

    t_lfu_state  r_state;
    t_lfu_state  n_state;
    logic        n_cond;
    logic        n_ifc;

    logic        r_out_vld;
    logic [31:0] r_flags;
    logic        r_cond;
    logic        r_ifc;

    t_flag_view  w_old;
    t_flag_view  w_new;
    logic        w_adv;
    logic        w_take;
    logic        w_test;

    lfu_eval u_eval_old (
        .i_state (r_state),
        .o_view  (w_old)
    );

    lfu_eval u_eval_new (
        .i_state (n_state),
        .o_view  (w_new)
    );

    assign w_adv  = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;
    assign w_take = i_valid && o_ready;

    function automatic t_lfu_state write_flags(input t_lfu_state s, input logic [31:0] nf);
        t_lfu_state t;
        t = s;
        t.fstore     = (s.fstore & ~WRITE_MASK) | (nf & WRITE_MASK);
        t.res        = {31'd0, ~nf[BIT_ZF]};
        t.sign_ovr   = nf[BIT_SF];
        t.parity_ovr = t.fstore[BIT_PF] ^ t.res[0] ^ 1'b1;
        t.kind       = K_FULL;
        return t;
    endfunction

    always_comb begin
        unique case (r_cc[3:1])
            COND_O:  w_test = w_old.of_f;
            COND_C:  w_test = w_old.cf_f;
            COND_Z:  w_test = w_old.zf_f;
            COND_BE: w_test = w_old.zf_f | w_old.cf_f;
            COND_S:  w_test = w_old.sf_f;
            COND_P:  w_test = w_old.pf_f;
            COND_L:  w_test = w_old.sf_f ^ w_old.of_f;
            default: w_test = w_old.zf_f | (w_old.sf_f ^ w_old.of_f);
        endcase
    end

    always_comb begin
        t_lfu_state  f;
        logic [31:0] oac;
        f   = r_state;
        oac = (r_state.fstore & ~OAC_MASK)
            | ({31'd0, w_old.of_f} << BIT_OF)
            | ({31'd0, w_old.af_f} << BIT_AF)
            | {31'd0, w_old.cf_f};
        f.fstore = oac;
        f.kind   = K_FULL;

        n_state = r_state;
        n_cond  = 1'b0;
        n_ifc   = 1'b0;
        unique case (r_cmd)
            CMD_RECORD: begin
                n_state.kind       = r_kind;
                n_state.res        = r_res;
                n_state.opa        = r_opa;
                n_state.opb        = r_opb;
                n_state.sign_ovr   = 1'b0;
                n_state.parity_ovr = 1'b0;
            end
            CMD_WRITE: begin
                n_state = write_flags(r_state, r_nflags);
                n_ifc   = r_state.fstore[BIT_IF] ^ n_state.fstore[BIT_IF];
            end
            CMD_FORCE: begin
                unique case (r_fsel)
                    FSEL_CF: begin
                        f.fstore[BIT_CF] = r_fval;
                        n_state = f;
                    end
                    FSEL_AF: begin
                        f.fstore[BIT_AF] = r_fval;
                        n_state = f;
                    end
                    FSEL_OF: begin
                        f.fstore[BIT_OF] = r_fval;
                        n_state = f;
                    end
                    FSEL_PF: begin
                        n_state.parity_ovr = r_state.parity_ovr ^ w_old.pf_f ^ r_fval;
                    end
                    FSEL_ZF: begin
                        n_state = write_flags(r_state,
                            (w_old.word & ~(32'd1 << BIT_ZF)) | ({31'd0, r_fval} << BIT_ZF));
                    end
                    FSEL_SF: begin
                        n_state.sign_ovr = r_state.res[31] ^ r_fval;
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
            CMD_TEST: begin
                n_cond = w_test ^ r_cc[0];
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd    <= i_command;
            r_kind   <= i_op_kind;
            r_res    <= i_result_value;
            r_opa    <= i_first_operand;
            r_opb    <= i_second_operand;
            r_nflags <= i_new_flags;
            r_fsel   <= i_flag_select;
            r_fval   <= i_flag_value;
            r_cc     <= i_condition_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_flags <= w_new.word;
            r_cond  <= n_cond;
            r_ifc   <= n_ifc;
        end
    end

    assign o_valid                  = r_out_vld;
    assign o_flags_out              = r_flags;
    assign o_condition_true         = r_cond;
    assign o_interrupt_flag_changed = r_ifc;

endmodule

### rtl/lfu_eval.sv
// Materializes the arithmetic flags and the EFLAGS word from a lazy flags state.
module lfu_eval (
    input  lfu_pkg::t_lfu_state i_state,
    output lfu_pkg::t_flag_view o_view
);
    import lfu_pkg::*;

    t_decode     w_dec;
    t_width      w_wid;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [31:0] w_r;
    logic [31:0] w_m;
    logic [31:0] w_sum;
    logic [31:0] w_diff;
    logic [31:0] w_cnt_m1;
    logic        w_lsh_bit;
    logic        w_rsh_bit;
    logic        w_shld16_bit;
    logic        w_cf;
    logic        w_of;
    logic        w_af;
    logic        w_sf;
    logic        w_zf;
    logic        w_pf;
    logic [7:0]  w_pbyte;

    assign w_dec    = lfu_decode(i_state.kind);
    assign w_wid    = w_dec.wid;
    assign w_a      = i_state.opa;
    assign w_b      = i_state.opb;
    assign w_r      = i_state.res;
    assign w_m      = lfu_mask(w_wid);
    assign w_sum    = w_r + w_b;
    assign w_diff   = w_r - w_b;
    assign w_cnt_m1 = w_b - 32'd1;

    assign w_lsh_bit = lfu_top_bit(w_a, lfu_wval(w_wid), w_b);
    assign w_rsh_bit = (w_b != 32'd0 && w_b <= 32'd32) ? w_a[w_cnt_m1[4:0]] : 1'b0;
    assign w_shld16_bit = (w_b <= 32'd16) ? lfu_top_bit(w_a, 6'd16, w_b)
                                          : lfu_top_bit(w_a, 6'd32, w_b);

    always_comb begin
        unique case (w_dec.grp)
            G_ADD:         w_cf = (w_r & w_m) < (w_b & w_m);
            G_SUB:         w_cf = (w_b & w_m) > (w_sum & w_m);
            G_ADC:         w_cf = lfu_msb(w_a ^ ((w_a ^ w_b) & (w_b ^ w_r)), w_wid);
            G_SBB:         w_cf = lfu_msb(w_r ^ ((w_r ^ w_b) & (w_a ^ w_b)), w_wid);
            G_SHL:         w_cf = w_lsh_bit;
            G_SHR, G_SAR:  w_cf = w_rsh_bit;
            G_INC, G_DEC:  w_cf = i_state.fstore[BIT_CF];
            default: begin
                unique case (w_dec.kind)
                    K_MUL:              w_cf = (w_a != w_b);
                    K_BIT:              w_cf = 1'b0;
                    K_SHLD16:           w_cf = w_shld16_bit;
                    K_SHLD32:           w_cf = lfu_top_bit(w_a, 6'd32, w_b);
                    K_SHRD16, K_SHRD32: w_cf = w_rsh_bit;
                    default:            w_cf = i_state.fstore[BIT_CF];
                endcase
            end
        endcase
    end

    always_comb begin
        unique case (w_dec.grp)
            G_ADD:   w_of = lfu_msb(~(w_diff ^ w_b) & (w_b ^ w_r), w_wid);
            G_SUB:   w_of = lfu_msb((w_sum ^ w_b) & (w_sum ^ w_r), w_wid);
            G_ADC:   w_of = lfu_msb((w_a ^ w_r) & (w_b ^ w_r), w_wid);
            G_SBB:   w_of = lfu_msb((w_r ^ w_a) & (w_b ^ w_a), w_wid);
            G_SHL:   w_of = lfu_msb(w_r, w_wid) ^ w_lsh_bit;
            G_SHR:   w_of = lfu_msb({w_r[30:0], 1'b0} ^ w_r, w_wid);
            G_SAR:   w_of = 1'b0;
            G_INC:   w_of = (w_r & w_m) == ((w_m >> 1) + 32'd1);
            G_DEC:   w_of = (w_r & w_m) == (w_m >> 1);
            default: begin
                unique case (w_dec.kind)
                    K_MUL:    w_of = (w_a != w_b);
                    K_BIT:    w_of = 1'b0;
                    K_SHLD16: w_of = w_cf ^ w_r[15];
                    K_SHLD32: w_of = w_cf ^ w_r[31];
                    K_SHRD16: w_of = w_r[14] ^ w_r[15];
                    K_SHRD32: w_of = w_r[30] ^ w_r[31];
                    default:  w_of = i_state.fstore[BIT_OF];
                endcase
            end
        endcase
    end

    always_comb begin
        unique case (w_dec.grp)
            G_ADD:               w_af = w_diff[4] ^ w_b[4] ^ w_r[4];
            G_SUB:               w_af = w_sum[4] ^ w_b[4] ^ w_r[4];
            G_ADC, G_SBB:        w_af = w_a[4] ^ w_b[4] ^ w_r[4];
            G_INC:               w_af = (w_r[3:0] == 4'h0);
            G_DEC:               w_af = (w_r[3:0] == 4'hF);
            G_SHL, G_SHR, G_SAR: w_af = 1'b0;
            default:             w_af = (w_dec.kind == K_FULL) ? i_state.fstore[BIT_AF] : 1'b0;
        endcase
    end

    assign w_sf    = w_r[31] ^ i_state.sign_ovr;
    assign w_zf    = (w_r == 32'd0);
    assign w_pbyte = w_r[7:0] ^ {i_state.parity_ovr, 7'd0};
    assign w_pf    = ~(^w_pbyte);

    always_comb begin
        o_view.of_f = w_of;
        o_view.sf_f = w_sf;
        o_view.zf_f = w_zf;
        o_view.af_f = w_af;
        o_view.pf_f = w_pf;
        o_view.cf_f = w_cf;
        o_view.word = i_state.fstore & ~MATERIAL_MASK;
        o_view.word[BIT_OF] = w_of;
        o_view.word[BIT_SF] = w_sf;
        o_view.word[BIT_ZF] = w_zf;
        o_view.word[BIT_AF] = w_af;
        o_view.word[BIT_PF] = w_pf;
        o_view.word[BIT_CF] = w_cf;
    end

endmodule

### bench/testbench.sv
// Self-checking testbench for the lazy x86 flags unit, with a built-in flag predictor.
`timescale 1ns / 100ps

module testbench;
    import lfu_pkg::*;

    localparam logic [5:0] K_ADD8  = 6'd2;
    localparam logic [5:0] K_ADD32 = 6'd4;
    localparam logic [5:0] K_SUB16 = 6'd6;
    localparam logic [5:0] K_ADC32 = 6'd10;
    localparam logic [5:0] K_SBB8  = 6'd11;
    localparam logic [5:0] K_SHL8  = 6'd14;
    localparam logic [5:0] K_SHL32 = 6'd16;
    localparam logic [5:0] K_SHR16 = 6'd18;
    localparam logic [5:0] K_SAR32 = 6'd22;
    localparam logic [5:0] K_INC8  = 6'd23;
    localparam logic [5:0] K_DEC16 = 6'd27;
    localparam logic [5:0] K_UNKNOWN_TOP = 6'd63;
    localparam logic [2:0] CMD_NONE  = 3'd7;
    localparam logic [2:0] FSEL_NONE = 3'd7;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int PRESSURE_AFTER = 700;
    localparam int PRESSURE_HOLD  = 250;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef struct packed {
        logic [2:0]  command;
        logic [5:0]  kind;
        logic [31:0] res;
        logic [31:0] opa;
        logic [31:0] opb;
        logic [31:0] nflags;
        logic [2:0]  fsel;
        logic        fval;
        logic [3:0]  cc;
    } t_flags_cmd;

    typedef struct packed {
        logic [31:0] flags;
        logic        cond;
        logic        ifc;
    } t_flags_result;

    typedef struct packed {
        t_flags_cmd    item;
        bit            typed;
        t_flags_result out;
    } t_bench_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_command = CMD_READ;
    logic [5:0]  i_op_kind = K_FULL;
    logic [31:0] i_result_value = 32'd0;
    logic [31:0] i_first_operand = 32'd0;
    logic [31:0] i_second_operand = 32'd0;
    logic [31:0] i_new_flags = 32'd0;
    logic [2:0]  i_flag_select = FSEL_CF;
    logic        i_flag_value = 1'b0;
    logic [3:0]  i_condition_code = 4'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_flags_out;
    logic        o_condition_true;
    logic        o_interrupt_flag_changed;

    logic [31:0] sh_res = 32'd1;
    logic [31:0] sh_opa = 32'd0;
    logic [31:0] sh_opb = 32'd0;
    logic [5:0]  sh_kind = K_FULL;
    logic        sh_sign_inv = 1'b0;
    logic        sh_par_inv = 1'b0;
    logic [31:0] sh_fword = FLAGS_RESET;

    t_flags_result flags_pending[$];
    t_bench_row    directed_rows[$];
    t_flags_result want;
    int            err_count = 0;
    int            checked_count = 0;
    int            cycle_count = 0;
    bit            sender_steady = 1'b0;

    x86_lazy_flags_unit_top dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_valid                  (i_valid),
        .o_ready                  (o_ready),
        .i_command                (i_command),
        .i_op_kind                (i_op_kind),
        .i_result_value           (i_result_value),
        .i_first_operand          (i_first_operand),
        .i_second_operand         (i_second_operand),
        .i_new_flags              (i_new_flags),
        .i_flag_select            (i_flag_select),
        .i_flag_value             (i_flag_value),
        .i_condition_code         (i_condition_code),
        .o_valid                  (o_valid),
        .i_ready                  (i_ready),
        .o_flags_out              (o_flags_out),
        .o_condition_true         (o_condition_true),
        .o_interrupt_flag_changed (o_interrupt_flag_changed)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic bit_pos(input logic [31:0] x, input longint pos);
        logic b;
        b = 1'b0;
        if (pos >= 0 && pos <= 31) begin
            b = x[int'(pos)];
        end
        return b;
    endfunction

    function automatic void kind_info(output t_group g, output int w, output logic [5:0] kn);
        int idx;
        kn = (sh_kind > K_FULL) ? K_FULL : sh_kind;
        g = G_OTHER;
        w = 32;
        if (kn >= K_ARITH_FIRST && kn <= K_ARITH_LAST) begin
            idx = int'(kn) - int'(K_ARITH_FIRST);
            g = t_group'(4'(idx / 3));
            w = 8 << (idx % 3);
        end
    endfunction

    function automatic logic [31:0] width_ones(input int w);
        return (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    endfunction

    function automatic logic carry_now();
        t_group      g;
        int          w;
        logic [5:0]  kn;
        logic [31:0] m;
        logic [31:0] t;
        longint      cnt;
        logic        c;
        kind_info(g, w, kn);
        m = width_ones(w);
        cnt = longint'({32'd0, sh_opb});
        c = sh_fword[BIT_CF];
        case (g)
            G_ADD: c = (sh_res & m) < (sh_opb & m);
            G_SUB: begin
                t = sh_opb + sh_res;
                c = (sh_opb & m) > (t & m);
            end
            G_ADC: begin
                t = sh_opa ^ ((sh_opa ^ sh_opb) & (sh_opb ^ sh_res));
                c = t[w-1];
            end
            G_SBB: begin
                t = sh_res ^ ((sh_res ^ sh_opb) & (sh_opa ^ sh_opb));
                c = t[w-1];
            end
            G_SHL: c = bit_pos(sh_opa, longint'(w) - cnt);
            G_SHR, G_SAR: c = bit_pos(sh_opa, cnt - 1);
            G_INC, G_DEC: c = sh_fword[BIT_CF];
            default: begin
                case (kn)
                    K_MUL: c = (sh_opa != sh_opb);
                    K_BIT: c = 1'b0;
                    K_SHLD16: c = (cnt <= 16) ? bit_pos(sh_opa, 16 - cnt)
                                              : bit_pos(sh_opa, 32 - cnt);
                    K_SHLD32: c = bit_pos(sh_opa, 32 - cnt);
                    K_SHRD16, K_SHRD32: c = bit_pos(sh_opa, cnt - 1);
                    default: c = sh_fword[BIT_CF];
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic overflow_now();
        t_group      g;
        int          w;
        logic [5:0]  kn;
        logic [31:0] m;
        logic [31:0] x;
        logic [31:0] t;
        logic [31:0] top;
        logic        o;
        kind_info(g, w, kn);
        m = width_ones(w);
        top = 32'd1 << (w - 1);
        o = sh_fword[BIT_OF];
        case (g)
            G_ADD: begin
                x = sh_res - sh_opb;
                t = (x ^ sh_opb ^ m) & (sh_opb ^ sh_res);
                o = t[w-1];
            end
            G_SUB: begin
                x = sh_opb + sh_res;
                t = (x ^ sh_opb) & (x ^ sh_res);
                o = t[w-1];
            end
            G_ADC: begin
                t = (sh_opa ^ sh_res) & (sh_opb ^ sh_res);
                o = t[w-1];
            end
            G_SBB: begin
                t = (sh_res ^ sh_opa) & (sh_opb ^ sh_opa);
                o = t[w-1];
            end
            G_SHL: o = sh_res[w-1] ^ bit_pos(sh_opa, longint'(w) - longint'({32'd0, sh_opb}));
            G_SHR: o = sh_res[w-1] ^ sh_res[w-2];
            G_SAR: o = 1'b0;
            G_INC: o = ((sh_res & m) == top);
            G_DEC: o = ((sh_res & m) == (top - 32'd1));
            default: begin
                case (kn)
                    K_MUL: o = (sh_opa != sh_opb);
                    K_BIT: o = 1'b0;
                    K_SHLD16: o = carry_now() ^ sh_res[15];
                    K_SHLD32: o = carry_now() ^ sh_res[31];
                    K_SHRD16: o = sh_res[15] ^ sh_res[14];
                    K_SHRD32: o = sh_res[31] ^ sh_res[30];
                    default: o = sh_fword[BIT_OF];
                endcase
            end
        endcase
        return o;
    endfunction

    function automatic logic aux_now();
        t_group      g;
        int          w;
        logic [5:0]  kn;
        logic [31:0] t;
        logic        a;
        kind_info(g, w, kn);
        a = 1'b0;
        case (g)
            G_ADD: begin
                t = (sh_res - sh_opb) ^ sh_opb ^ sh_res;
                a = t[4];
            end
            G_SUB: begin
                t = (sh_res + sh_opb) ^ sh_opb ^ sh_res;
                a = t[4];
            end
            G_ADC, G_SBB: begin
                t = sh_opa ^ sh_opb ^ sh_res;
                a = t[4];
            end
            G_INC: a = (sh_res[3:0] == 4'h0);
            G_DEC: a = (sh_res[3:0] == 4'hF);
            G_SHL, G_SHR, G_SAR: a = 1'b0;
            default: a = (kn == K_FULL) ? sh_fword[BIT_AF] : 1'b0;
        endcase
        return a;
    endfunction

    function automatic logic parity_now();
        return ~^(sh_res[7:0] ^ {sh_par_inv, 7'd0});
    endfunction

    function automatic logic [31:0] flags_now();
        logic [31:0] f;
        f = sh_fword & ~MATERIAL_MASK;
        f[BIT_OF] = overflow_now();
        f[BIT_SF] = sh_res[31] ^ sh_sign_inv;
        f[BIT_ZF] = (sh_res == 32'd0);
        f[BIT_AF] = aux_now();
        f[BIT_PF] = parity_now();
        f[BIT_CF] = carry_now();
        return f;
    endfunction

    function automatic logic store_flags(input logic [31:0] nf);
        logic [31:0] prev;
        prev = sh_fword;
        sh_fword = (sh_fword & ~WRITE_MASK) | (nf & WRITE_MASK);
        sh_res = {31'd0, ~nf[BIT_ZF]};
        sh_sign_inv = nf[BIT_SF];
        sh_par_inv = sh_fword[BIT_PF] ^ sh_res[0] ^ 1'b1;
        sh_kind = K_FULL;
        return prev[BIT_IF] ^ sh_fword[BIT_IF];
    endfunction

    function automatic void settle_oac(input int pos, input logic v);
        logic [31:0] oac;
        oac = 32'd0;
        oac[BIT_OF] = overflow_now();
        oac[BIT_AF] = aux_now();
        oac[BIT_CF] = carry_now();
        sh_fword = (sh_fword & ~OAC_MASK) | oac;
        sh_fword[pos] = v;
        sh_kind = K_FULL;
    endfunction

    function automatic logic cond_now(input logic [3:0] cc);
        logic c;
        case (cc[3:1])
            COND_O:  c = overflow_now();
            COND_C:  c = carry_now();
            COND_Z:  c = (sh_res == 32'd0);
            COND_BE: c = (sh_res == 32'd0) | carry_now();
            COND_S:  c = sh_res[31] ^ sh_sign_inv;
            COND_P:  c = parity_now();
            COND_L:  c = (sh_res[31] ^ sh_sign_inv) ^ overflow_now();
            default: c = (sh_res == 32'd0) | ((sh_res[31] ^ sh_sign_inv) ^ overflow_now());
        endcase
        return c ^ cc[0];
    endfunction

    function automatic t_flags_result eflags_step(input t_flags_cmd it);
        t_flags_result o;
        logic [31:0]   f;
        o = '0;
        case (it.command)
            CMD_RECORD: begin
                sh_kind = it.kind;
                sh_res = it.res;
                sh_opa = it.opa;
                sh_opb = it.opb;
                sh_sign_inv = 1'b0;
                sh_par_inv = 1'b0;
            end
            CMD_WRITE: o.ifc = store_flags(it.nflags);
            CMD_FORCE: begin
                case (it.fsel)
                    FSEL_CF: settle_oac(BIT_CF, it.fval);
                    FSEL_PF: sh_par_inv = sh_par_inv ^ parity_now() ^ it.fval;
                    FSEL_AF: settle_oac(BIT_AF, it.fval);
                    FSEL_ZF: begin
                        f = flags_now();
                        f[BIT_ZF] = it.fval;
                        void'(store_flags(f));
                    end
                    FSEL_SF: sh_sign_inv = sh_res[31] ^ it.fval;
                    FSEL_OF: settle_oac(BIT_OF, it.fval);
                    default: ;
                endcase
            end
            CMD_TEST: o.cond = cond_now(it.cc);
            default: ;
        endcase
        o.flags = flags_now();
        return o;
    endfunction

    function automatic void add_row(input logic [2:0] c, input logic [5:0] k,
                                    input logic [31:0] r, input logic [31:0] a,
                                    input logic [31:0] b, input logic [31:0] nf,
                                    input logic [2:0] fs, input logic fv, input logic [3:0] cc,
                                    input bit typed = 1'b0, input logic [31:0] ef = 32'd0,
                                    input logic ec = 1'b0, input logic ei = 1'b0);
        t_bench_row row;
        row.item = '{command: c, kind: k, res: r, opa: a, opb: b, nflags: nf,
                     fsel: fs, fval: fv, cc: cc};
        row.typed = typed;
        row.out = '{flags: ef, cond: ec, ifc: ei};
        directed_rows.push_back(row);
    endfunction

    function automatic logic [31:0] corner_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0: w = 32'd0;
            1: w = 32'hFFFF_FFFF;
            2: w = 32'h8000_0000;
            3: w = 32'h7FFF_FFFF;
            4: w = 32'($urandom_range(0, 255));
            default: w = $urandom;
        endcase
        return w;
    endfunction

    function automatic t_flags_cmd random_cmd();
        t_flags_cmd it;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.command = CMD_RECORD;
        end else if (pick < 52) begin
            it.command = CMD_READ;
        end else if (pick < 62) begin
            it.command = CMD_WRITE;
        end else if (pick < 80) begin
            it.command = CMD_FORCE;
        end else if (pick < 96) begin
            it.command = CMD_TEST;
        end else begin
            it.command = 3'($urandom_range(5, 7));
        end
        it.kind = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(34, 63))
                                             : 6'($urandom_range(0, 33));
        it.opa = corner_word();
        it.opb = corner_word();
        if (((it.kind >= K_SHL8 && it.kind <= K_SAR32) ||
             (it.kind >= K_SHLD16 && it.kind <= K_SHRD32)) && $urandom_range(0, 7) != 0) begin
            it.opb = 32'($urandom_range(0, 40));
        end
        case ($urandom_range(0, 3))
            0: it.res = it.opa + it.opb;
            1: it.res = it.opa - it.opb;
            2: it.res = it.opa << it.opb[4:0];
            default: it.res = corner_word();
        endcase
        it.nflags = $urandom;
        it.fsel = 3'($urandom_range(0, 7));
        it.fval = 1'($urandom_range(0, 1));
        it.cc = 4'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic offer_item(input t_flags_cmd it, input bit typed, input t_flags_result typed_out);
        int            gap;
        int            pick;
        t_flags_result predicted;
        gap = 0;
        if (!sender_steady) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92) begin
                gap = $urandom_range(6, 30);
            end else if (pick >= 60) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= it.command;
        i_op_kind <= it.kind;
        i_result_value <= it.res;
        i_first_operand <= it.opa;
        i_second_operand <= it.opb;
        i_new_flags <= it.nflags;
        i_flag_select <= it.fsel;
        i_flag_value <= it.fval;
        i_condition_code <= it.cc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = eflags_step(it);
        flags_pending.push_back(typed ? typed_out : predicted);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (flags_pending.size() == 0) begin
                $error("result item with no command outstanding");
                err_count++;
            end else begin
                want = flags_pending.pop_front();
                checked_count++;
                if (o_flags_out !== want.flags) begin
                    $error("flags_out: expected %h, got %h", want.flags, o_flags_out);
                    err_count++;
                end
                if (o_condition_true !== want.cond) begin
                    $error("condition_true: expected %b, got %b", want.cond, o_condition_true);
                    err_count++;
                end
                if (o_interrupt_flag_changed !== want.ifc) begin
                    $error("interrupt_flag_changed: expected %b, got %b",
                           want.ifc, o_interrupt_flag_changed);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int  stall_left;
        int  pick;
        int  rx_cycle;
        bit  pressure_done;
        stall_left = 0;
        rx_cycle = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (stall_left == 0 && !pressure_done && checked_count >= PRESSURE_AFTER) begin
                stall_left = PRESSURE_HOLD;
                pressure_done = 1'b1;
            end else if (stall_left == 0 && ((rx_cycle / 400) % 4) != 3) begin
                pick = $urandom_range(0, 99);
                if (pick >= 95) begin
                    stall_left = $urandom_range(8, 40);
                end else if (pick >= 75) begin
                    stall_left = $urandom_range(1, 3);
                end
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        add_row(CMD_READ, K_FULL, 0, 0, 0, 0, FSEL_CF, 0, 0, 1, FLAGS_RESET, 0, 0);
        add_row(CMD_WRITE, K_FULL, 0, 0, 0, 32'hFFFF_FFFF, FSEL_CF, 0, 0,
                1, 32'h003F_7FD7, 0, 1);
        add_row(CMD_TEST, K_FULL, 0, 0, 0, 0, FSEL_CF, 0, {COND_LE, 1'b1});
        add_row(CMD_WRITE, K_FULL, 0, 0, 0, 32'd0, FSEL_CF, 0, 0, 1, FLAGS_RESET, 0, 1);
        add_row(CMD_NONE, K_FULL, 0, 0, 0, 0, FSEL_CF, 0, 0, 1, FLAGS_RESET, 0, 0);
        add_row(CMD_RECORD, K_ADD8, 32'h0, 32'hFF, 32'h1, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_ADD32, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_SUB16, 32'hFFFF, 32'h0, 32'h1, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_ADC32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_SBB8, 32'h80, 32'h7F, 32'hFF, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_SHL32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_SHL8, 32'h0, 32'h81, 32'd40, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_SHR16, 32'h4000, 32'h8001, 32'h1, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_SAR32, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0,
                FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_INC8, 32'h80, 32'h7F, 32'h1, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_DEC16, 32'h7FFF, 32'h8000, 32'h1, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_MUL, 32'h2, 32'h1, 32'h2, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_SHLD16, 32'h5678_0000, 32'h1234_5678, 32'd20, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_SHRD32, 32'h8000_0000, 32'h1, 32'h1, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_UNKNOWN_TOP, 32'h0, 32'h0, 32'h0, 0, FSEL_CF, 0, 0);
        add_row(CMD_RECORD, K_BIT, 32'h0, 32'hFFFF_FFFF, 32'h0, 0, FSEL_CF, 0, 0);
        add_row(CMD_FORCE, K_FULL, 0, 0, 0, 0, FSEL_CF, 1, 0);
        add_row(CMD_FORCE, K_FULL, 0, 0, 0, 0, FSEL_PF, 0, 0);
        add_row(CMD_FORCE, K_FULL, 0, 0, 0, 0, FSEL_AF, 1, 0);
        add_row(CMD_FORCE, K_FULL, 0, 0, 0, 0, FSEL_ZF, 0, 0);
        add_row(CMD_FORCE, K_FULL, 0, 0, 0, 0, FSEL_SF, 1, 0);
        add_row(CMD_FORCE, K_FULL, 0, 0, 0, 0, FSEL_OF, 1, 0);
        add_row(CMD_FORCE, K_FULL, 0, 0, 0, 0, FSEL_NONE, 1, 0);
        add_row(CMD_TEST, K_FULL, 0, 0, 0, 0, FSEL_CF, 0, {COND_O, 1'b0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            offer_item(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].out);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_steady = ((n / 150) % 3) == 1;
            offer_item(random_cmd(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (flags_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
